FILE: rtl/rdp_command_fill_engine_macros.svh
// Assertion macros shared by the fill engine modules.
`ifndef RDP_COMMAND_FILL_ENGINE_MACROS_SVH
`define RDP_COMMAND_FILL_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset.
`define RDP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define RDP_ASSERT_ALWAYS(lbl, cond, msg)

`define RDP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/rfe_pkg.sv
// Shared constants, codes and beat types of the fill engine.
package rfe_pkg;

  localparam int ADDR_BITS    = 23;
  localparam int WRITE_ADDR_W = 23;
  localparam int WORD_W       = 64;
  localparam int DATA_W       = 32;
  localparam int HALF_W       = DATA_W / 2;
  localparam int COORD_W      = 10;
  localparam int WIDTH_W      = COORD_W + 1;
  localparam int OFFSET_W     = COORD_W + WIDTH_W;
  localparam int SCALED_W     = OFFSET_W + 2;
  localparam int OPCODE_W     = 6;
  localparam int PIX_SIZE_W   = 2;

  // Output queue
  localparam int FIFO_DEPTH   = 3;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  // Command opcodes
  localparam logic [OPCODE_W-1:0] OP_FILL_RECT       = 6'h36;
  localparam logic [OPCODE_W-1:0] OP_SET_FILL_COLOR  = 6'h37;
  localparam logic [OPCODE_W-1:0] OP_SET_COLOR_IMAGE = 6'h3F;

  // Item kinds
  localparam logic ACT_COMMAND = 1'b0;
  localparam logic ACT_TICK    = 1'b1;

  localparam logic [PIX_SIZE_W-1:0] PIX_SIZE_32 = 2'd3;

  // One pixel write waiting for address and data formation
  typedef struct packed {
    logic [COORD_W-1:0]   row;
    logic [COORD_W-1:0]   col;
    logic [WIDTH_W-1:0]   width;
    logic [ADDR_BITS-1:0] base;
    logic [DATA_W-1:0]    fill;
    logic                 wide;
    logic                 last;
  } rfe_req_t;

  // One finished write beat
  typedef struct packed {
    logic [WRITE_ADDR_W-1:0] addr;
    logic [DATA_W-1:0]       data;
    logic                    wide;
    logic                    last;
  } rfe_wr_t;

endpackage

FILE: rtl/rfe_sequencer.sv
// Command decode, image/fill registers and the X-outer, Y-inner fill walk.
`include "rdp_command_fill_engine_macros.svh"

module rfe_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic                            action,
  input  logic [rfe_pkg::WORD_W-1:0]      command_word,
  output rfe_pkg::rfe_req_t               req,
  output logic                            req_valid
);
  import rfe_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FILL = 2'b10
  } fill_state_t;

  fill_state_t            state;
  logic [ADDR_BITS-1:0]   image_address;
  logic [WIDTH_W-1:0]     image_width;
  logic [PIX_SIZE_W-1:0]  pixel_size;
  logic [DATA_W-1:0]      fill_value;
  logic [COORD_W-1:0]     column_now;
  logic [COORD_W-1:0]     row_now;
  logic [COORD_W-1:0]     row_first;
  logic [COORD_W-1:0]     column_final;
  logic [COORD_W-1:0]     row_final;

  logic [OPCODE_W-1:0]    opcode;
  logic [COORD_W-1:0]     x0, y0, x1, y1;
  logic                   cmd_fire;
  logic                   tick_fire;
  logic                   fill_ok;
  logic                   at_row_end;
  logic                   at_col_end;
  logic                   is_last;

  // Field extraction; 10.2 coordinates drop their fraction bits
  assign opcode = command_word[61:56];
  assign x1     = command_word[55:46];
  assign y1     = command_word[43:34];
  assign x0     = command_word[23:14];
  assign y0     = command_word[11:2];

  assign cmd_fire  = accept && (action == ACT_COMMAND) && (state == ST_IDLE);
  assign tick_fire = accept && (action == ACT_TICK) && (state == ST_FILL);
  assign fill_ok   = pixel_size[1] && (x0 <= x1) && (y0 <= y1);

  assign at_row_end = (row_now == row_final);
  assign at_col_end = (column_now == column_final);
  assign is_last    = at_row_end && at_col_end;

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      req_valid     <= 1'b0;
      image_address <= '0;
      image_width   <= '0;
      pixel_size    <= '0;
      fill_value    <= '0;
      column_now    <= '0;
      row_now       <= '0;
      row_first     <= '0;
      column_final  <= '0;
      row_final     <= '0;
    end else begin
      req_valid <= tick_fire;
      if (cmd_fire) begin
        case (opcode)
          OP_SET_COLOR_IMAGE: begin
            pixel_size    <= command_word[52:51];
            image_width   <= {1'b0, command_word[41:32]} + WIDTH_W'(1);
            image_address <= command_word[ADDR_BITS-1:0];
          end
          OP_SET_FILL_COLOR: begin
            fill_value <= command_word[DATA_W-1:0];
          end
          OP_FILL_RECT: begin
            if (fill_ok) begin
              state        <= ST_FILL;
              column_now   <= x0;
              row_now      <= y0;
              row_first    <= y0;
              column_final <= x1;
              row_final    <= y1;
            end
          end
          default: begin
          end
        endcase
      end
      // Walk: Y steps first, X steps when a column is done
      if (tick_fire) begin
        if (at_row_end) begin
          if (at_col_end) begin
            state <= ST_IDLE;
          end else begin
            column_now <= column_now + COORD_W'(1);
            row_now    <= row_first;
          end
        end else begin
          row_now <= row_now + COORD_W'(1);
        end
      end
    end
  end

  // Snapshot of everything the write needs, so later commands cannot disturb it
  always_ff @(posedge clk) begin
    if (tick_fire) begin
      req.row   <= row_now;
      req.col   <= column_now;
      req.width <= image_width;
      req.base  <= image_address;
      req.fill  <= fill_value;
      req.wide  <= (pixel_size == PIX_SIZE_32);
      req.last  <= is_last;
    end
  end

  `RDP_ASSERT_NEXT(a_idle_no_req, state == ST_IDLE, !req_valid, "write issued while idle")
  `RDP_ASSERT_NEXT(a_last_ends_fill, tick_fire && is_last, state == ST_IDLE, "fill not ended")
  `RDP_ASSERT_ALWAYS(a_walk_in_rect, (state != ST_FILL) || ((row_now <= row_final) && (column_now <= column_final)), "walk left rectangle")

endmodule

FILE: rtl/rfe_pixel_calc.sv
// Byte address and big-endian data formation for one pixel write.
module rfe_pixel_calc (
  input  rfe_pkg::rfe_req_t req,
  output rfe_pkg::rfe_wr_t  wr
);
  import rfe_pkg::*;

  logic [OFFSET_W-1:0]  offset;
  logic [SCALED_W-1:0]  scaled;
  logic [ADDR_BITS-1:0] addr_sum;
  logic [HALF_W-1:0]    half;

  // Pixel offset in the image: row * width + column
  assign offset = (OFFSET_W'(req.row) * OFFSET_W'(req.width)) + OFFSET_W'(req.col);

  // Scale to bytes: 4 per wide pixel, 2 per narrow pixel
  assign scaled = req.wide ? {offset, 2'b00} : {1'b0, offset, 1'b0};

  // Base plus byte offset, wrapping at the address width
  assign addr_sum = req.base + ADDR_BITS'(scaled);

  // Narrow pixels: high half at even offsets, low half at odd ones
  assign half = offset[0] ? req.fill[HALF_W-1:0] : req.fill[DATA_W-1:HALF_W];

  assign wr.addr = WRITE_ADDR_W'(addr_sum);
  assign wr.data = req.wide ? req.fill : {{(DATA_W - HALF_W){1'b0}}, half};
  assign wr.wide = req.wide;
  assign wr.last = req.last;

endmodule

FILE: rtl/rfe_out_fifo.sv
// Small output queue that holds write beats while the consumer stalls.
`include "rdp_command_fill_engine_macros.svh"

module rfe_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rfe_pkg::rfe_wr_t push_data,
  input  logic             pending,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output rfe_pkg::rfe_wr_t out_data
);
  import rfe_pkg::*;

  rfe_wr_t                 mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr;
  logic [FIFO_PTR_W-1:0]   rd_ptr;
  logic [FIFO_CNT_W-1:0]   count;
  logic                    pop;

  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;

  // Room check counts the beat already in the calc stage
  assign full = (count == FIFO_CNT_W'(FIFO_DEPTH)) ||
                ((count == FIFO_CNT_W'(FIFO_DEPTH - 1)) && pending);

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + FIFO_CNT_W'(1);
      end else if (!push && pop) begin
        count <= count - FIFO_CNT_W'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  `RDP_ASSERT_ALWAYS(a_no_overflow, !(push && !pop && (count == FIFO_CNT_W'(FIFO_DEPTH))), "output queue overflow")

endmodule

FILE: rtl/rdp_command_fill_engine.sv
// Top level of the rectangle fill engine for 64-bit display commands.
//
//   channel  signals                                           dir  handshake
//   in       action, command_word                              in   in_valid / in_stall
//   out      write_address, write_data, write_wide, last_write out  out_valid / out_stall
//
// One item per clock while in_stall is low; a tick during a fill yields its write beat
// through the snapshot register, then address/data logic into a 3-entry output queue.
// The 10x11 offset multiply plus the base add set the critical path.
// in_stall comes from registers only: it rises when the queue, counting the beat in
// flight, would be full. Commands and ticks are stalled alike.
// Reset is synchronous; control state and queue level clear at once, no clearing pass.
module rdp_command_fill_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                action,
  input  logic [rfe_pkg::WORD_W-1:0]          command_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rfe_pkg::WRITE_ADDR_W-1:0]    write_address,
  output logic [rfe_pkg::DATA_W-1:0]          write_data,
  output logic                                write_wide,
  output logic                                last_write
);
  import rfe_pkg::*;

  rfe_req_t req;
  logic     req_valid;
  rfe_wr_t  wr;
  rfe_wr_t  out_data;
  logic     accept;
  logic     queue_full;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;

  rfe_sequencer u_seq (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .action       (action),
    .command_word (command_word),
    .req          (req),
    .req_valid    (req_valid)
  );

  rfe_pixel_calc u_calc (
    .req (req),
    .wr  (wr)
  );

  rfe_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (req_valid),
    .push_data (wr),
    .pending   (req_valid),
    .full      (queue_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Unpack the beat onto the result ports
  assign write_address = out_data.addr;
  assign write_data    = out_data.data;
  assign write_wide    = out_data.wide;
  assign last_write    = out_data.last;

endmodule
